FILE: design/integer_literal_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Integer literal parser - assertion macros
// Shared property wrappers for the port checker; clocked on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define ILP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer literal parser: same-cycle check failed");

// Next-cycle implication.
`define ILP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer literal parser: next-cycle check failed");

`endif

FILE: design/ilp_pkg.sv
// ----------------------------------------------------------------------------
// Integer literal parser - package
// Widths, character codes, beat class type and token phase shared by the parser modules and the testbench.
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int VALUE_W = 16;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CASE_MASK  = 8'h5f;
  localparam logic [7:0] CH_HIGHBIT = 8'h80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified character, as carried from front to back.
  typedef struct packed {
    logic       term;      // code below '0'
    logic       minus;
    logic       dollar;
    logic       dec;       // '0'..'9'
    logic       hexl;      // a-f or A-F
    logic [3:0] dval;      // digit value when dec or hexl
  } class_t;

  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

endpackage

FILE: design/integer_literal_parser_core.sv
// ----------------------------------------------------------------------------
// Integer literal parser core
// Streams characters of a token and returns its integer value on the terminator.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained, while results are taken.
// Path: a terminator is written into the class queue, then popped by the token
//   back end, which registers its result and drops empty.
// Reset (rst, synchronous, active high) empties both queues, clears the token
//   state and sets hex_default to 0 (base 10).
// ----------------------------------------------------------------------------
module integer_literal_parser_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                hex_default_we,
  input  logic                                hex_default,
  // character side
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          char_code,
  // result side
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ilp_pkg::VALUE_W-1:0]  value,
  output logic [ilp_pkg::COUNT_W-1:0]         digit_count,
  output logic                                is_number
);

  // Base selection register; the user must write it only while no token is in flight (not enforced here).
  logic            hex_dflt;

  ilp_pkg::class_t front_cls;
  ilp_pkg::class_t q_data;
  logic            q_empty;
  logic            q_pop;
  logic            res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_dflt <= 1'b0;
    end else if (hex_default_we) begin
      hex_dflt <= hex_default;
    end
  end

  // Front: classify the character as it arrives, with no token state.
  ilp_front u_front (
    .char_code (char_code),
    .cls       (front_cls)
  );

  // Decouple classification from the token state; full throttles the source.
  ilp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_cls),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: advance the token state one beat per cycle; hold a terminator beat
  // only while the result slot is still occupied and not being popped.
  ilp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .hex_default (hex_dflt),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_take    (pop && res_valid),
    .res_value   (value),
    .res_count   (digit_count),
    .res_isnum   (is_number)
  );

  assign empty = !res_valid;

endmodule

FILE: design/ilp_front.sv
// ----------------------------------------------------------------------------
// Integer literal parser - front end
// Classifies each incoming character into sign, prefix, terminator or digit.
// ----------------------------------------------------------------------------
module ilp_front (
  input  logic [7:0]    char_code,
  output ilp_pkg::class_t cls
);

  logic [7:0] upper;

  always_comb begin
    upper      = char_code & ilp_pkg::CASE_MASK;
    cls.term   = char_code < ilp_pkg::CH_ZERO;
    cls.minus  = char_code == ilp_pkg::CH_MINUS;
    cls.dollar = char_code == ilp_pkg::CH_DOLLAR;
    cls.dec    = (char_code >= ilp_pkg::CH_ZERO) && (char_code <= ilp_pkg::CH_NINE);
    cls.hexl   = (char_code < ilp_pkg::CH_HIGHBIT) &&
                 (upper >= ilp_pkg::CH_UP_A) && (upper <= ilp_pkg::CH_UP_F);
    // letters: low nibble 1..6 maps to 10..15
    cls.dval   = cls.dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
  end

endmodule

FILE: design/ilp_queue.sv
// ----------------------------------------------------------------------------
// Integer literal parser - class queue
// Short queue of classified beats between the front and the back end.
// ----------------------------------------------------------------------------
module ilp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ilp_pkg::class_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output ilp_pkg::class_t rd_data,
  output logic            empty
);

  ilp_pkg::class_t                 mem [ilp_pkg::QUEUE_DEPTH];
  logic [ilp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ilp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ilp_pkg::QCNT_W-1:0]      count;

  assign full    = count == ilp_pkg::QCNT_W'(ilp_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == ilp_pkg::QPTR_W'(ilp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == ilp_pkg::QPTR_W'(ilp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/ilp_back.sv
// ----------------------------------------------------------------------------
// Integer literal parser - back end
// Runs the token state and accumulator, and holds the finished result.
// ----------------------------------------------------------------------------
module ilp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hex_default,
  input  logic                                q_empty,
  input  ilp_pkg::class_t                     q_data,
  output logic                                q_pop,
  output logic                                res_valid,
  input  logic                                res_take,
  output logic signed [ilp_pkg::VALUE_W-1:0]  res_value,
  output logic [ilp_pkg::COUNT_W-1:0]         res_count,
  output logic                                res_isnum
);

  logic [ilp_pkg::VALUE_W-1:0] acc, acc_next;
  logic                        neg, neg_next;
  logic                        hexm, hexm_next;
  ilp_pkg::phase_t             phase, phase_next;
  logic [ilp_pkg::COUNT_W-1:0] digits, digits_next;
  logic                        bad, bad_next;

  logic                        early, eff_hex, good, emit, ok;
  logic [ilp_pkg::VALUE_W-1:0] scaled, signed_acc;

  always_comb begin
    early = (phase == ilp_pkg::PH_SIGN) || (phase == ilp_pkg::PH_PREFIX);
    eff_hex = early ? hex_default : hexm;
    good    = q_data.dec || (eff_hex && q_data.hexl);
    scaled  = eff_hex ? (acc << 4) : ((acc << 3) + (acc << 1));
    ok      = (digits != '0) && !bad;
    signed_acc = neg ? (~acc + 1'b1) : acc;

    acc_next    = acc;
    neg_next    = neg;
    hexm_next   = hexm;
    phase_next  = phase;
    digits_next = digits;
    bad_next    = bad;
    emit        = 1'b0;

    if (phase == ilp_pkg::PH_SIGN && q_data.minus) begin
      neg_next   = 1'b1;
      phase_next = ilp_pkg::PH_PREFIX;
    end else if (early && q_data.dollar) begin
      hexm_next  = 1'b1;
      phase_next = ilp_pkg::PH_DIGITS;
    end else if (q_data.term) begin
      emit        = 1'b1;
      acc_next    = '0;
      neg_next    = 1'b0;
      hexm_next   = 1'b0;
      phase_next  = ilp_pkg::PH_SIGN;
      digits_next = '0;
      bad_next    = 1'b0;
    end else begin
      if (early) begin
        hexm_next  = hex_default;
        phase_next = ilp_pkg::PH_DIGITS;
      end
      if (!bad) begin
        if (!good) begin
          bad_next = 1'b1;
        end else begin
          acc_next = scaled + ilp_pkg::VALUE_W'(q_data.dval);
          if (digits != ilp_pkg::COUNT_MAX) begin
            digits_next = digits + 1'b1;
          end
        end
      end
    end

    // a terminator needs the result slot free, or freed this cycle
    q_pop = !q_empty && (!q_data.term || !res_valid || res_take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      neg    <= 1'b0;
      hexm   <= 1'b0;
      phase  <= ilp_pkg::PH_SIGN;
      digits <= '0;
      bad    <= 1'b0;
    end else if (q_pop) begin
      acc    <= acc_next;
      neg    <= neg_next;
      hexm   <= hexm_next;
      phase  <= phase_next;
      digits <= digits_next;
      bad    <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop && emit) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res_value <= ok ? signed_acc : '0;
      res_count <= ok ? digits : '0;
      res_isnum <= ok;
    end
  end

endmodule

FILE: design/ilp_checker.sv
// ----------------------------------------------------------------------------
// Integer literal parser - port checker
// Watches the top-level ports for result consistency and stall behaviour.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_core_assert.svh"

module ilp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                empty,
  input logic                                pop,
  input logic signed [ilp_pkg::VALUE_W-1:0]  value,
  input logic [ilp_pkg::COUNT_W-1:0]         digit_count,
  input logic                                is_number
);

  // An invalid token reports zero value and zero digits.
  `ILP_ASSERT_NOW(a_invalid_zero, !empty && !is_number, value == '0 && digit_count == '0)

  // A valid token has at least one digit.
  `ILP_ASSERT_NOW(a_valid_digits, !empty && is_number, digit_count != '0)

  // A waiting result that is not popped stays put.
  `ILP_ASSERT_NEXT(a_hold_result, !empty && !pop,
                   !empty && $stable(value) && $stable(digit_count) && $stable(is_number))

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .value       (value),
  .digit_count (digit_count),
  .is_number   (is_number)
);

FILE: tb/sv/integer_literal_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser - result checker
// Watches the character, result and configuration ports, works out the
// literal that each terminator beat should produce, and compares every
// popped result against the oldest outstanding literal, field by field.
// ----------------------------------------------------------------------------
module integer_literal_parser_checker
  import ilp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hex_default_we,
  input  logic                       hex_default,
  input  logic                       push,
  input  logic                       full,
  input  logic [7:0]                 char_code,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [COUNT_W-1:0]         digit_count,
  input  logic                       is_number,
  output int                         pending,
  output int                         fail_count
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
    logic               is_number;
  } literal_t;

  // Shadow of the token state and of the base register.
  logic [VALUE_W-1:0] acc;
  logic               neg;
  logic               hexm;
  logic               bad;
  logic               cfg_hex;
  phase_t             ph;
  logic [COUNT_W-1:0] ndig;

  literal_t literal_q[$];
  int       mismatch_total = 0;

  function automatic void clear_token_state();
    acc  = '0;
    neg  = 1'b0;
    hexm = 1'b0;
    bad  = 1'b0;
    ph   = PH_SIGN;
    ndig = '0;
  endfunction

  // Advance the token by one character; queue a literal on a terminator.
  task automatic parse_char(input logic [7:0] c);
    literal_t   lit;
    logic       good;
    logic [3:0] d;
    logic [7:0] u;
    if (ph == PH_SIGN && c == CH_MINUS) begin
      neg = 1'b1;
      ph  = PH_PREFIX;
    end else if ((ph == PH_SIGN || ph == PH_PREFIX) && c == CH_DOLLAR) begin
      hexm = 1'b1;
      ph   = PH_DIGITS;
    end else if (c < CH_ZERO) begin
      lit.is_number   = (ndig != '0) && !bad;
      lit.value       = lit.is_number ? (neg ? -acc : acc) : '0;
      lit.digit_count = lit.is_number ? ndig : '0;
      literal_q.push_back(lit);
      clear_token_state();
    end else begin
      // the base is fixed by the first character past the prefix
      if (ph == PH_SIGN || ph == PH_PREFIX) begin
        hexm = cfg_hex;
        ph   = PH_DIGITS;
      end
      if (!bad) begin
        good = 1'b1;
        d    = '0;
        if (c <= CH_NINE) begin
          d = 4'(c - CH_ZERO);
        end else if (!hexm || c >= CH_HIGHBIT) begin
          good = 1'b0;
        end else begin
          u = c & CASE_MASK;
          if (u < CH_UP_A || u > CH_UP_F) begin
            good = 1'b0;
          end else begin
            d = 4'(u - CH_UP_A + 8'd10);
          end
        end
        if (!good) begin
          bad = 1'b1;
        end else begin
          acc = VALUE_W'(acc * (hexm ? VALUE_W'(16) : VALUE_W'(10)) + VALUE_W'(d));
          if (ndig != COUNT_MAX) begin
            ndig = ndig + 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    literal_t want;
    if (rst) begin
      cfg_hex = 1'b0;
      clear_token_state();
      literal_q.delete();
    end else begin
      if (hex_default_we) begin
        cfg_hex = hex_default;
      end
      // a result beat can never belong to a character taken at the same edge
      if (pop && !empty) begin
        if (literal_q.size() == 0) begin
          $error("result with nothing outstanding: value %0d, digit_count %0d, is_number %0b",
                 value, digit_count, is_number);
          mismatch_total++;
        end else begin
          want = literal_q.pop_front();
          if (value !== $signed(want.value)) begin
            $error("value: expected %0d, got %0d", $signed(want.value), value);
            mismatch_total++;
          end
          if (digit_count !== want.digit_count) begin
            $error("digit_count: expected %0d, got %0d", want.digit_count, digit_count);
            mismatch_total++;
          end
          if (is_number !== want.is_number) begin
            $error("is_number: expected %0b, got %0b", want.is_number, is_number);
            mismatch_total++;
          end
        end
      end
      if (push && !full) begin
        parse_char(char_code);
      end
    end
    pending    <= literal_q.size();
    fail_count <= mismatch_total;
  end

endmodule

FILE: tb/sv/tb_integer_literal_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser core - regression
// Streams short directed tokens and then randomised tokens through the core
// under both settings of the base register, with random idle bursts on
// both queue sides, a long result-side hold-off and a full drain mid-run.
// The checker beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_integer_literal_parser_core;
  import ilp_pkg::*;

  localparam int         SEG_ITEMS   = 312;    // character beats per random segment
  localparam int         SEGMENTS    = 4;
  localparam int         LONG_HOLD   = 150;    // result-side hold-off, in cycles
  localparam int         LONG_TOKEN  = 270;    // enough digits to saturate the count
  localparam int         DRAIN_SLACK = 4;      // covers the two stages: class queue and back end
  localparam longint     TIMEOUT_NS  = 10_000_000;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_TERM_MAX = CH_ZERO - 8'd1;

  // Directed tokens, sent from the top byte down:
  //   "99" ended by NUL, the lowest code
  //   "-$fF" ended by '/', the highest terminator code
  //   a lone sign, a lone prefix ended by a second '$'
  //   '-' after a digit, and a second '-' after the sign, both as terminators
  //   a hex letter in base 10, a code with the top bit set, and '`' after '$'
  localparam int DIRECTED_N = 25;
  localparam logic [8*DIRECTED_N-1:0] DIRECTED = {
    8'h39, 8'h39, 8'h00,
    8'h2d, 8'h24, 8'h66, 8'h46, 8'h2f,
    8'h2d, 8'h20,
    8'h24, 8'h24,
    8'h31, 8'h2d,
    8'h31, 8'h61, 8'h20,
    8'h2d, 8'h2d,
    8'hff, 8'h37, 8'h20,
    8'h24, 8'h60, 8'h20
  };

  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      hex_default_we = 1'b0;
  logic                      hex_default    = 1'b0;
  logic                      push           = 1'b0;
  logic [7:0]                char_code      = 8'h00;
  logic                      pop            = 1'b0;
  logic                      full;
  logic                      empty;
  logic signed [VALUE_W-1:0] value;
  logic [COUNT_W-1:0]        digit_count;
  logic                      is_number;

  // Sender-to-receiver controls: a toggle asks for the long hold-off,
  // quiet switches idling off for the last part of the run.
  logic hold_tog = 1'b0;
  logic quiet    = 1'b0;

  int pending;
  int fail_count;
  int sent = 0;

  always #10 clk = ~clk;

  integer_literal_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .hex_default_we (hex_default_we),
    .hex_default    (hex_default),
    .push           (push),
    .full           (full),
    .char_code      (char_code),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .digit_count    (digit_count),
    .is_number      (is_number)
  );

  integer_literal_parser_checker literal_check (
    .clk            (clk),
    .rst            (rst),
    .hex_default_we (hex_default_we),
    .hex_default    (hex_default),
    .push           (push),
    .full           (full),
    .char_code      (char_code),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .digit_count    (digit_count),
    .is_number      (is_number),
    .pending        (pending),
    .fail_count     (fail_count)
  );

  // Offer one character and hold it until the core takes the beat. An idle
  // burst may come first; push is then left high, so back-to-back beats
  // never see it drop and rise within one step.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Drop push and wait until every outstanding result has been popped,
  // then give the pipeline time to settle any beat that makes no result.
  task automatic wait_drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write the base register; only ever called with the core drained.
  task automatic set_hex_default(input logic b);
    hex_default_we <= 1'b1;
    hex_default    <= b;
    @(posedge clk);
    hex_default_we <= 1'b0;
  endtask

  // One token: mostly well-formed literals in the right base with random
  // sign, prefix, length and letter case; the rest is noise or a literal
  // broken by a stray character. Terminators span the whole code range
  // below '0', so '-' and '$' sometimes act as sign or prefix instead.
  task automatic send_token();
    int         n;
    logic       hexy;
    logic [3:0] d;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send_char(8'($urandom_range(0, 255)));
    end else begin
      hexy = hex_default;
      if ($urandom_range(0, 1) == 1) send_char(CH_MINUS);
      if ($urandom_range(0, 3) == 0) begin
        send_char(CH_DOLLAR);
        hexy = 1'b1;
      end
      n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 7);
      repeat (n) begin
        d = hexy ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
        if (d > 4'd9) begin
          send_char(($urandom_range(0, 1) == 1 ? CH_LOW_A : CH_UP_A) + 8'(d - 4'd10));
        end else begin
          send_char(CH_ZERO + 8'(d));
        end
      end
      if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(CH_ZERO, 255)));
    end
    send_char(8'($urandom_range(0, CH_TERM_MAX)));
  endtask

  // Receiver: pop freely, idle in random bursts, and honour a long
  // hold-off when the sender asks for one.
  initial begin : receiver
    logic hold_seen;
    int   burst;
    hold_seen = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        pop <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 9);
        pop <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int seg_end;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens in base 10, straight after reset.
    for (int i = DIRECTED_N - 1; i >= 0; i--) begin
      send_char(DIRECTED[i*8 +: 8]);
    end
    wait_drain();

    // Random segments, alternating the base register between its two values.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_hex_default(seg % 2 == 0);
      seg_end = sent + SEG_ITEMS;
      if (seg == 1) begin
        // Saturate the count first, then hold the result side off while
        // short tokens keep coming, so the queues fill up and full pushes back.
        repeat (LONG_TOKEN) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        send_char(CH_SPACE);
        hold_tog <= ~hold_tog;
      end
      if (seg == SEGMENTS - 1) begin
        quiet <= 1'b1;
      end
      while (sent < seg_end) begin
        send_token();
        if (seg == 2 && sent >= seg_end - SEG_ITEMS / 2 && sent < seg_end - SEG_ITEMS / 2 + 8) begin
          // Pause the sender until every result is back, near the middle of the segment.
          wait_drain();
        end
      end
      // Close any token left open before the register changes.
      send_char(CH_SPACE);
      wait_drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("integer_literal_parser_core regression: pass");
    end else begin
      $display("integer_literal_parser_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("integer_literal_parser_core regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ilp_pkg.sv
design/ilp_front.sv
design/ilp_queue.sv
design/ilp_back.sv
design/integer_literal_parser_core.sv
design/ilp_checker.sv
tb/sv/integer_literal_parser_checker.sv
tb/sv/tb_integer_literal_parser_core.sv
